// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/crcfd_pkg.sv
// ----------------------------------------------------------------------------
// crcfd_pkg
// Types, constants and the CRC-16 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package crcfd_pkg;

    localparam int LEN_W = 14;

    localparam logic [7:0]       START_BYTE = 8'h55;
    localparam logic [LEN_W-1:0] LEN_MAX    = 14'h3FFF;
    localparam logic [15:0]      CRC_POLY   = 16'hA001;
    localparam logic [15:0]      CRC_INIT   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_HDR    = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_CRC_HI = 3'd5,
        PH_DATA   = 3'd6
    } phase_t;

    // tuser bit positions, lowest first
    localparam int U_PAYLOAD_VALID = 0;
    localparam int U_FRAME_GOOD    = 1;
    localparam int U_HEADER_ERROR  = 2;
    localparam int U_LENGTH_ERROR  = 3;

    // Modbus CRC-16, reflected, one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/crc16_frame_decoder.sv
// ----------------------------------------------------------------------------
// crc16_frame_decoder
// Byte-serial packet deframer with Modbus CRC-16 check.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one received byte per request (s_tdata). Each accepted byte gives
//   exactly one request on m_axis in the next cycle, in input order.
//   Frame: 0x55, length low, length high, header check, CRC low, CRC high,
//   then the payload bytes, which pass through with the payload_valid flag.
//   m_tlast marks the byte that completes a frame; frame_good and
//   frame_length are valid there. Header or length errors drop the frame and
//   are flagged on the offending byte.
//   Throughput is 1 byte per cycle, set by the single output register, which
//   takes a new byte whenever it is empty or being drained in the same cycle.
//   When m_tready is low with a result pending, s_tready drops and the
//   deframer state holds until the result is taken.
//   Reset (aresetn low, synchronous) returns to waiting for a start byte,
//   empties the output register and sets max_frame_length to 16383.
//   cfg_we/cfg_wdata write max_frame_length; write only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc16_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_frame_length
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [21:8] frame_length, [23:22] zero
    output logic [3:0]  m_tuser,   // [0] payload_valid, [1] frame_good,
                                   // [2] header_error, [3] length_error
    output logic        m_tlast    // frame_end
);

    localparam int LW = crcfd_pkg::LEN_W;

    logic [LW-1:0]      max_len_reg;
    crcfd_pkg::phase_t  phase_reg, phase_next;
    logic [LW-1:0]      plen_reg, plen_next;
    logic [7:0]         hsum_reg, hsum_next;
    logic [15:0]        exp_crc_reg, exp_crc_next;
    logic [15:0]        run_crc_reg, run_crc_next;
    logic [LW-1:0]      count_reg, count_next;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [LW-1:0]      out_len_reg, out_len_next;
    logic [3:0]         out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    logic               in_req;
    logic [LW-1:0]      len_full;
    logic [15:0]        crc_full;
    logic [15:0]        crc_step;
    logic [LW-1:0]      count_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_req   = s_tvalid && s_tready;

    assign len_full  = {s_tdata[LW-9:0], plen_reg[7:0]};
    assign crc_full  = {s_tdata, exp_crc_reg[7:0]};
    assign crc_step  = crcfd_pkg::crc16_update(run_crc_reg, s_tdata);
    assign count_inc = count_reg + LW'(1);

    // next state
    always_comb begin
        phase_next   = phase_reg;
        plen_next    = plen_reg;
        hsum_next    = hsum_reg;
        exp_crc_next = exp_crc_reg;
        run_crc_next = run_crc_reg;
        count_next   = count_reg;
        case (phase_reg)
            crcfd_pkg::PH_START: begin
                if (s_tdata == crcfd_pkg::START_BYTE) begin
                    hsum_next    = crcfd_pkg::START_BYTE;
                    run_crc_next = crcfd_pkg::CRC_INIT;
                    phase_next   = crcfd_pkg::PH_LEN_LO;
                end
            end
            crcfd_pkg::PH_LEN_LO: begin
                plen_next  = {{(LW-8){1'b0}}, s_tdata};
                hsum_next  = hsum_reg ^ s_tdata;
                phase_next = crcfd_pkg::PH_LEN_HI;
            end
            crcfd_pkg::PH_LEN_HI: begin
                plen_next  = len_full;
                hsum_next  = hsum_reg ^ s_tdata;
                count_next = '0;
                if (len_full > max_len_reg) begin
                    phase_next = crcfd_pkg::PH_START;
                end else begin
                    phase_next = crcfd_pkg::PH_HDR;
                end
            end
            crcfd_pkg::PH_HDR: begin
                if (s_tdata != hsum_reg) begin
                    phase_next = crcfd_pkg::PH_START;
                end else begin
                    phase_next = crcfd_pkg::PH_CRC_LO;
                end
            end
            crcfd_pkg::PH_CRC_LO: begin
                exp_crc_next = {8'h00, s_tdata};
                phase_next   = crcfd_pkg::PH_CRC_HI;
            end
            crcfd_pkg::PH_CRC_HI: begin
                exp_crc_next = crc_full;
                run_crc_next = crcfd_pkg::CRC_INIT;
                count_next   = '0;
                if (plen_reg == '0) begin
                    phase_next = crcfd_pkg::PH_START;
                end else begin
                    phase_next = crcfd_pkg::PH_DATA;
                end
            end
            crcfd_pkg::PH_DATA: begin
                run_crc_next = crc_step;
                count_next   = count_inc;
                if (count_inc == plen_reg) begin
                    phase_next = crcfd_pkg::PH_START;
                end
            end
            default: begin
                phase_next = crcfd_pkg::PH_START;
            end
        endcase
    end

    // result fields
    always_comb begin
        out_byte_next = '0;
        out_len_next  = '0;
        out_user_next = '0;
        out_last_next = 1'b0;
        case (phase_reg)
            crcfd_pkg::PH_LEN_HI: begin
                out_user_next[crcfd_pkg::U_LENGTH_ERROR] = (len_full > max_len_reg);
            end
            crcfd_pkg::PH_HDR: begin
                out_user_next[crcfd_pkg::U_HEADER_ERROR] = (s_tdata != hsum_reg);
            end
            crcfd_pkg::PH_CRC_HI: begin
                if (plen_reg == '0) begin
                    out_last_next = 1'b1;
                    out_user_next[crcfd_pkg::U_FRAME_GOOD] = (crc_full == crcfd_pkg::CRC_INIT);
                end
            end
            crcfd_pkg::PH_DATA: begin
                out_byte_next = s_tdata;
                out_user_next[crcfd_pkg::U_PAYLOAD_VALID] = 1'b1;
                if (count_inc == plen_reg) begin
                    out_last_next = 1'b1;
                    out_len_next  = plen_reg;
                    out_user_next[crcfd_pkg::U_FRAME_GOOD] = (crc_step == exp_crc_reg);
                end
            end
            default: begin
                out_last_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= crcfd_pkg::LEN_MAX;
            phase_reg     <= crcfd_pkg::PH_START;
            plen_reg      <= '0;
            hsum_reg      <= crcfd_pkg::START_BYTE;
            exp_crc_reg   <= '0;
            run_crc_reg   <= crcfd_pkg::CRC_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (in_req) begin
                phase_reg     <= phase_next;
                plen_reg      <= plen_next;
                hsum_reg      <= hsum_next;
                exp_crc_reg   <= exp_crc_next;
                run_crc_reg   <= run_crc_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_req) begin
            out_byte_reg <= out_byte_next;
            out_len_reg  <= out_len_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-LW-8){1'b0}}, out_len_reg, out_byte_reg};
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // payload byte in gives a flagged payload result
    `ASSERT_NEXT(a_data_passes, aclk, aresetn,
        in_req && phase_reg == crcfd_pkg::PH_DATA,
        m_tvalid && m_tuser[crcfd_pkg::U_PAYLOAD_VALID])

    // hunting for a start byte reports nothing
    `ASSERT_NEXT(a_start_quiet, aclk, aresetn,
        in_req && phase_reg == crcfd_pkg::PH_START,
        m_tvalid && m_tuser == 4'b0000 && !m_tlast)

    // a dropped frame leaves the deframer hunting again
    `ASSERT_SAME(a_drop_resyncs, aclk, aresetn,
        m_tvalid && (m_tuser[crcfd_pkg::U_HEADER_ERROR] || m_tuser[crcfd_pkg::U_LENGTH_ERROR]),
        phase_reg == crcfd_pkg::PH_START && !m_tlast)

endmodule

// File: tb/sv/tb_crc16_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_crc16_frame_decoder
// Self-checking bench for the byte-serial CRC-16 frame decoder. Drives a mix
// of clean frames, bad CRCs, bad headers, oversize lengths and line noise
// through the input stream under random valid/ready gaps. A scoreboard class
// tracks the deframer state per accepted byte and checks every result request
// field by field. max_frame_length is rewritten between traffic phases.
// ----------------------------------------------------------------------------
module tb_crc16_frame_decoder;
    import crcfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600_000;

    typedef enum {FAULT_NONE, FAULT_CRC, FAULT_HDR} frame_fault_t;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             frame_end;
        logic             frame_good;
        logic [LEN_W-1:0] frame_length;
        logic             header_error;
        logic             length_error;
    } deframe_result_t;

    class deframe_scoreboard;
        phase_t           ph;
        logic [15:0]      len_word;
        logic [7:0]       hdr_acc;
        logic [15:0]      rx_crc;
        logic [15:0]      calc_crc;
        logic [LEN_W-1:0] byte_cnt;
        logic [LEN_W-1:0] max_len;
        deframe_result_t  predicted_results[$];
        int               errors;

        function new();
            ph       = PH_START;
            len_word = '0;
            hdr_acc  = START_BYTE;
            rx_crc   = '0;
            calc_crc = CRC_INIT;
            byte_cnt = '0;
            max_len  = LEN_MAX;
            errors   = 0;
        endfunction

        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            logic        lsb;
            c = crc ^ {8'h00, b};
            repeat (8) begin
                lsb = c[0];
                c   = c >> 1;
                if (lsb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void set_max_len(logic [LEN_W-1:0] v);
            max_len = v;
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction

        function void accept_byte(logic [7:0] b);
            deframe_result_t r;
            r = '0;
            case (ph)
                PH_START: begin
                    if (b == START_BYTE) begin
                        hdr_acc  = START_BYTE;
                        calc_crc = CRC_INIT;
                        ph       = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    len_word = {8'h00, b};
                    hdr_acc  = hdr_acc ^ b;
                    ph       = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_word = {b, len_word[7:0]};
                    hdr_acc  = hdr_acc ^ b;
                    byte_cnt = '0;
                    if (len_word[LEN_W-1:0] > max_len) begin
                        r.length_error = 1'b1;
                        ph             = PH_START;
                    end else begin
                        ph = PH_HDR;
                    end
                end
                PH_HDR: begin
                    if (b != hdr_acc) begin
                        r.header_error = 1'b1;
                        ph             = PH_START;
                    end else begin
                        len_word = {2'b00, len_word[LEN_W-1:0]};
                        ph       = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    rx_crc = {8'h00, b};
                    ph     = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    rx_crc   = {b, rx_crc[7:0]};
                    calc_crc = CRC_INIT;
                    byte_cnt = '0;
                    if (len_word[LEN_W-1:0] == '0) begin
                        r.frame_end  = 1'b1;
                        r.frame_good = (calc_crc == rx_crc);
                        ph           = PH_START;
                    end else begin
                        ph = PH_DATA;
                    end
                end
                PH_DATA: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    calc_crc        = crc_step(calc_crc, b);
                    byte_cnt        = byte_cnt + 1'b1;
                    if (byte_cnt == len_word[LEN_W-1:0]) begin
                        r.frame_end    = 1'b1;
                        r.frame_good   = (calc_crc == rx_crc);
                        r.frame_length = len_word[LEN_W-1:0];
                        ph             = PH_START;
                    end
                end
                default: ph = PH_START;
            endcase
            predicted_results.push_back(r);
        endfunction

        function void compare(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] data, logic [3:0] user, logic last);
            deframe_result_t e;
            if (predicted_results.size() == 0) begin
                $error("result request with no prediction pending");
                errors++;
                return;
            end
            e = predicted_results.pop_front();
            compare("payload_valid", e.payload_valid, user[U_PAYLOAD_VALID]);
            compare("payload_byte", e.payload_byte, data[7:0]);
            compare("frame_end", e.frame_end, last);
            compare("frame_good", e.frame_good, user[U_FRAME_GOOD]);
            compare("frame_length", e.frame_length, data[8 +: LEN_W]);
            compare("header_error", e.header_error, user[U_HEADER_ERROR]);
            compare("length_error", e.length_error, user[U_LENGTH_ERROR]);
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [23:0]      m_tdata;
    logic [3:0]       m_tuser;
    logic             m_tlast;

    deframe_scoreboard sb;
    int unsigned       src_idle_pct = 0;
    int unsigned       snk_idle_pct = 0;
    logic              hold_rx      = 1'b0;
    logic [LEN_W-1:0]  max_len_cfg  = LEN_MAX;
    int unsigned       items_sent   = 0;
    int unsigned       cycle_cnt    = 0;

    crc16_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        sb = new();
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check, then pick ready for the next cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser, m_tlast);
            end
            m_tready <= !hold_rx && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.accept_byte(b);
        items_sent++;
    endtask

    task automatic send_frame(input logic [LEN_W-1:0] len, input frame_fault_t fault,
                              input logic [1:0] pad);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  hdr;
        logic [7:0]  b;
        logic [15:0] crc;
        logic [7:0]  body[$];
        lo  = len[7:0];
        hi  = {pad, len[LEN_W-1:8]};
        hdr = START_BYTE ^ lo ^ hi;
        if (fault == FAULT_HDR) begin
            hdr = hdr ^ 8'($urandom_range(255, 1));
        end
        send_byte(START_BYTE);
        send_byte(lo);
        send_byte(hi);
        if (len > max_len_cfg) begin
            return;
        end
        send_byte(hdr);
        if (fault == FAULT_HDR) begin
            return;
        end
        crc = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            body.push_back(b);
            crc = deframe_scoreboard::crc_step(crc, b);
        end
        if (fault == FAULT_CRC) begin
            crc = crc ^ 16'($urandom_range(65535, 1));
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_max(input logic [LEN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_max_len(v);
        max_len_cfg = v;
    endtask

    task automatic run_traffic(input int unsigned n);
        int unsigned      target;
        int unsigned      pick;
        int unsigned      lim;
        int unsigned      cnt;
        logic [LEN_W-1:0] len;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            lim  = (max_len_cfg < 24) ? max_len_cfg : 24;
            len  = LEN_W'($urandom_range(lim, 0));
            if ($urandom_range(24) == 0) begin
                len = LEN_W'($urandom_range((max_len_cfg < 400) ? max_len_cfg : 400, 0));
            end
            if (pick < 56) begin
                send_frame(len, FAULT_NONE, 2'($urandom));
            end else if (pick < 70) begin
                send_frame(len, FAULT_CRC, 2'($urandom));
            end else if (pick < 80) begin
                send_frame(len, FAULT_HDR, 2'($urandom));
            end else if (pick < 88) begin
                if (max_len_cfg != LEN_MAX) begin
                    if ($urandom_range(1) == 0) begin
                        len = max_len_cfg + 1'b1;
                    end else begin
                        len = LEN_W'($urandom_range(LEN_MAX, int'(max_len_cfg) + 1));
                    end
                    send_frame(len, FAULT_NONE, 2'($urandom));
                end
            end else begin
                // noise, sometimes a stray start byte that breaks the next frame
                cnt = $urandom_range(4, 1);
                repeat (cnt) begin
                    send_byte(($urandom_range(3) == 0) ? START_BYTE : 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        write_max(LEN_MAX);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(14'd0, FAULT_NONE, 2'b11);
        send_frame(14'd1, FAULT_NONE, 2'b10);
        send_frame(14'd2, FAULT_HDR, 2'b00);
        s_tvalid <= 1'b0;
        drain();
        write_max(14'd0);
        send_frame(14'd1, FAULT_NONE, 2'b01);
        send_frame(14'd0, FAULT_CRC, 2'b00);
        s_tvalid <= 1'b0;

        // random phases
        for (int seg = 0; seg < 6; seg++) begin
            drain();
            src_idle_pct <= (seg < 2) ? 13 : (seg < 4) ? 64 : 0;
            snk_idle_pct <= (seg < 2) ? 64 : (seg < 4) ? 13 : 0;
            case (seg)
                0: write_max(LEN_MAX);
                1: write_max(14'd0);
                2: write_max(LEN_W'($urandom_range(40, 1)));
                3: write_max(LEN_MAX);
                4: write_max(LEN_W'($urandom_range(100, 0)));
                default: write_max(14'd6);
            endcase
            if (seg == 5) begin
                fork
                    run_traffic(150);
                    begin
                        // long receiver stall so the output backs up into the input
                        repeat (40) @(posedge aclk);
                        hold_rx <= 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_rx <= 1'b0;
                    end
                join
            end else begin
                run_traffic(150);
            end
            s_tvalid <= 1'b0;
        end

        // one frame exactly at the configured limit
        drain();
        write_max(14'd300);
        send_frame(14'd300, FAULT_NONE, 2'($urandom));
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
